[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the console checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console check failed: same-cycle implication");

// next-cycle implication, quiet during reset
`define TCW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("console check failed: next-cycle implication");

// next-cycle implication that also watches the reset cycles
`define TCW_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("console check failed: next-cycle implication at reset");

`endif

[design/tcw_pkg.sv]
// ---------------------------------------------------------------------------
// tcw_pkg
// Types, codes and sizes shared by the text console controller, datapath
// and checker.
// ---------------------------------------------------------------------------
package tcw_pkg;

   // screen geometry limits
   localparam int MAX_COLS   = 128;
   localparam int MAX_ROWS   = 32;
   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int COLS_W     = 8;
   localparam int ROWS_W     = 6;
   localparam int POS_W      = 12;
   localparam int CHAR_W     = 8;
   localparam int CELL_W     = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // transaction modes
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR = 2'd2;

   // special characters
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

   // register reset values
   localparam logic [COLS_W-1:0] COLS_RESET  = 8'd80;
   localparam logic [ROWS_W-1:0] ROWS_RESET  = 6'd25;
   localparam logic [CHAR_W-1:0] COLOR_RESET = 8'd7;
   localparam logic [CELL_W-1:0] INIT_CELL   = {COLOR_RESET, CH_BLANK};

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } tcw_req_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_entry;
      logic              scrolled;
   } tcw_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic sat;
      logic put_char;
      logic line;
      logic bs_step;
      logic blank_cur;
      logic rd_issue;
      logic rd_capture;
      logic home;
      logic cnt_clear;
      logic cnt_cols;
      logic cnt_bottom;
      logic fill_step;
      logic fill_init;
      logic scroll_step;
      logic load_rsp;
   } tcw_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              is_newline;
      logic              is_backspace;
      logic              at_home;
      logic              col_wrap;
      logic              need_scroll;
      logic              sweep_end;
      logic              scroll_end;
      logic              init_end;
   } tcw_status_type;

endpackage

[design/tcw_datapath.sv]
// ---------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor, sweep counter, geometry registers and the result
// register of the text console.
// ---------------------------------------------------------------------------
module tcw_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  csr_data,
   input  tcw_pkg::tcw_req_type            req_data,
   input  tcw_pkg::tcw_cmd_type            cmd,
   output tcw_pkg::tcw_status_type         status,
   output tcw_pkg::tcw_rsp_type            rsp_data
);
   import tcw_pkg::*;

   // screen store, linear row-major layout
   logic [CELL_W-1:0] screen_mem [CELL_COUNT];

   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [CHAR_W-1:0] color_ff, color_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] paddr_ff, paddr_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   tcw_req_type       req_ff, req_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              scrolled_ff, scrolled_in;
   tcw_rsp_type       rsp_ff, rsp_in;
   logic [CELL_W-1:0] rdata_ff;

   logic [COLS_W-1:0]       cols_use;
   logic [ROWS_W-1:0]       rows_use;
   logic [ROW_W+COLS_W-1:0] cur_prod;
   logic [ROW_W+COLS_W-1:0] rd_prod;
   logic [ROWS_W+COLS_W-1:0] area_prod;
   logic [ADDR_W-1:0]       cur_idx;
   logic [ADDR_W-1:0]       rd_idx;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [CELL_W-1:0]       wr_data;
   logic                    col_wrap;
   logic                    need_scroll;
   logic [CELL_W-1:0]       blank_cell;

   // geometry in use, clamped to the supported range
   always_comb begin
      if (cols_ff == '0)
         cols_use = COLS_W'(1);
      else if (cols_ff > COLS_W'(MAX_COLS))
         cols_use = COLS_W'(MAX_COLS);
      else
         cols_use = cols_ff;
      if (rows_ff == '0)
         rows_use = ROWS_W'(1);
      else if (rows_ff > ROWS_W'(MAX_ROWS))
         rows_use = ROWS_W'(MAX_ROWS);
      else
         rows_use = rows_ff;
   end

   // cell addresses
   assign cur_prod   = row_ff * cols_use;
   assign cur_idx    = ADDR_W'(cur_prod + (ROW_W + COLS_W)'(col_ff));
   assign rd_prod    = req_ff.read_row * cols_use;
   assign rd_idx     = ADDR_W'(rd_prod + (ROW_W + COLS_W)'(req_ff.read_col));
   assign area_prod  = rows_use * cols_use;
   assign blank_cell = {color_ff, CH_BLANK};

   // cursor conditions
   assign col_wrap    = (COLS_W'(col_ff) + COLS_W'(1)) >= cols_use;
   assign need_scroll = (ROWS_W'(row_ff) + ROWS_W'(1)) >= rows_use;

   // configuration registers
   always_comb begin
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      color_in = color_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COLS:  cols_in  = COLS_W'(csr_data);
            CSR_ROWS:  rows_in  = ROWS_W'(csr_data);
            CSR_COLOR: color_in = CHAR_W'(csr_data);
            default:   ;
         endcase
      end
   end

   // cursor update
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.sat) begin
         if (ROWS_W'(row_ff) >= rows_use)
            row_in = ROW_W'(rows_use - ROWS_W'(1));
         if (COLS_W'(col_ff) >= cols_use)
            col_in = COL_W'(cols_use - COLS_W'(1));
      end else if (cmd.put_char) begin
         col_in = col_wrap ? '0 : col_ff + COL_W'(1);
      end else if (cmd.line) begin
         col_in = '0;
         if (!need_scroll)
            row_in = row_ff + ROW_W'(1);
      end else if (cmd.bs_step) begin
         if (col_ff == '0) begin
            col_in = COL_W'(cols_use - COLS_W'(1));
            row_in = row_ff - ROW_W'(1);
         end else begin
            col_in = col_ff - COL_W'(1);
         end
      end else if (cmd.home) begin
         row_in = '0;
         col_in = '0;
      end
   end

   // sweep counter and scroll copy pipeline
   always_comb begin
      cnt_in   = cnt_ff;
      pend_in  = 1'b0;
      paddr_in = paddr_ff;
      if (cmd.cnt_clear)
         cnt_in = '0;
      else if (cmd.cnt_cols)
         cnt_in = CNT_W'(cols_use);
      else if (cmd.cnt_bottom)
         cnt_in = total_ff - CNT_W'(cols_use);
      else if (cmd.fill_step || cmd.scroll_step)
         cnt_in = cnt_ff + CNT_W'(1);
      if (cmd.scroll_step) begin
         pend_in  = 1'b1;
         paddr_in = ADDR_W'(cnt_ff - CNT_W'(cols_use));
      end
   end

   // transaction payload registers
   always_comb begin
      req_in      = req_ff;
      total_in    = total_ff;
      rd_ok_in    = rd_ok_ff;
      cell_in     = cell_ff;
      scrolled_in = scrolled_ff;
      rsp_in      = rsp_ff;
      if (cmd.take) begin
         req_in      = req_data;
         cell_in     = '0;
         scrolled_in = 1'b0;
      end
      if (cmd.sat)
         total_in = CNT_W'(area_prod);
      if (cmd.line && need_scroll)
         scrolled_in = 1'b1;
      if (cmd.rd_issue)
         rd_ok_in = (ROWS_W'(req_ff.read_row) < rows_use) &&
                    (COLS_W'(req_ff.read_col) < cols_use);
      if (cmd.rd_capture)
         cell_in = rd_ok_ff ? rdata_ff : '0;
      if (cmd.load_rsp) begin
         rsp_in.cursor_row = row_ff;
         rsp_in.cursor_col = col_ff;
         rsp_in.cursor_pos = POS_W'(cur_idx);
         rsp_in.cell_entry = cell_ff;
         rsp_in.scrolled   = scrolled_ff;
      end
   end

   // memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[ADDR_W-1:0];
      wr_data = blank_cell;
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = paddr_ff;
         wr_data = rdata_ff;
      end else if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_data = cmd.fill_init ? INIT_CELL : blank_cell;
      end else if (cmd.put_char) begin
         wr_en   = 1'b1;
         wr_addr = cur_idx;
         wr_data = {color_ff, req_ff.char_code};
      end else if (cmd.blank_cur) begin
         wr_en   = 1'b1;
         wr_addr = cur_idx;
      end
   end

   assign rd_addr = cmd.rd_issue ? rd_idx : cnt_ff[ADDR_W-1:0];

   // screen memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en)
         screen_mem[wr_addr] <= wr_data;
      rdata_ff <= screen_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COLS_RESET;
         rows_ff  <= ROWS_RESET;
         color_ff <= COLOR_RESET;
         row_ff   <= '0;
         col_ff   <= '0;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         color_ff <= color_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      paddr_ff    <= paddr_in;
      total_ff    <= total_in;
      req_ff      <= req_in;
      rd_ok_ff    <= rd_ok_in;
      cell_ff     <= cell_in;
      scrolled_ff <= scrolled_in;
      rsp_ff      <= rsp_in;
   end

   // status back to the controller
   assign status.mode         = req_ff.mode;
   assign status.is_newline   = req_ff.char_code == CH_NEWLINE;
   assign status.is_backspace = req_ff.char_code == CH_BACKSPACE;
   assign status.at_home      = (row_ff == '0) && (col_ff == '0);
   assign status.col_wrap     = col_wrap;
   assign status.need_scroll  = need_scroll;
   assign status.sweep_end    = cnt_ff >= total_ff;
   assign status.scroll_end   = (cnt_ff >= total_ff) && !pend_ff;
   assign status.init_end     = cnt_ff == CNT_W'(CELL_COUNT);

   assign rsp_data = rsp_ff;

endmodule

[design/tcw_controller.sv]
// ---------------------------------------------------------------------------
// tcw_controller
// Sequencer of the text console: request intake, per-mode step order,
// memory sweeps and the result handshake.
// ---------------------------------------------------------------------------
module tcw_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);
   import tcw_pkg::*;

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_SAT    = 4'd2;
   localparam logic [3:0] S_EXEC   = 4'd3;
   localparam logic [3:0] S_LINE   = 4'd4;
   localparam logic [3:0] S_BLANK  = 4'd5;
   localparam logic [3:0] S_RDWAIT = 4'd6;
   localparam logic [3:0] S_SCROLL = 4'd7;
   localparam logic [3:0] S_BOTTOM = 4'd8;
   localparam logic [3:0] S_CLEAR  = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            if (status.init_end) begin
               state_in = S_IDLE;
            end else begin
               cmd.fill_step = 1'b1;
               cmd.fill_init = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            cmd.sat  = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (status.mode)
               MODE_WRITE: begin
                  if (status.is_newline) begin
                     state_in = S_LINE;
                  end else if (status.is_backspace) begin
                     if (status.at_home) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.bs_step = 1'b1;
                        state_in    = S_BLANK;
                     end
                  end else begin
                     cmd.put_char = 1'b1;
                     state_in     = status.col_wrap ? S_LINE : S_DONE;
                  end
               end
               MODE_CLEAR: begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = S_CLEAR;
               end
               MODE_READ: begin
                  cmd.rd_issue = 1'b1;
                  state_in     = S_RDWAIT;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_LINE: begin
            cmd.line = 1'b1;
            if (status.need_scroll) begin
               cmd.cnt_cols = 1'b1;
               state_in     = S_SCROLL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BLANK: begin
            cmd.blank_cur = 1'b1;
            state_in      = S_DONE;
         end
         S_RDWAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_DONE;
         end
         // copy every row up by one, one cell a cycle
         S_SCROLL: begin
            if (status.scroll_end) begin
               cmd.cnt_bottom = 1'b1;
               state_in       = S_BOTTOM;
            end else if (!status.sweep_end) begin
               cmd.scroll_step = 1'b1;
            end
         end
         S_BOTTOM: begin
            if (status.sweep_end)
               state_in = S_DONE;
            else
               cmd.fill_step = 1'b1;
         end
         S_CLEAR: begin
            if (status.sweep_end) begin
               cmd.home = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp)
         rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/text_console_writer.sv]
// ---------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with a 4096-cell screen store and cursor.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per console operation (write character, clear
//            screen, read cell), taken when req_valid is high and req_stall
//            is low. req_stall is high whenever a transaction is in flight.
//   rsp_*  : one result per transaction, held in an output register until
//            taken (rsp_valid high, rsp_stall low); a new request is taken
//            while the previous result still waits.
//   csr_*  : register writes (columns, rows, colour), always ready; write
//            only while the console is idle.
// Steps: an accepted transaction passes S_SAT and S_EXEC, then S_DONE,
//   which loads the result. A newline or line wrap adds S_LINE, a backspace
//   that is not ignored adds S_BLANK and a cell read adds S_RDWAIT. A scroll
//   adds S_SCROLL and S_BOTTOM and a clear adds S_CLEAR; these sweeps are
//   set by the single memory write port walking cells.
// Reset: a clearing pass fills the store with blanks in
//   colour 7; req_stall stays high until it ends.
// A stalled result holds; the next one waits in the sequencer until the
//   output register frees.
// ---------------------------------------------------------------------------
module text_console_writer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tcw_pkg::tcw_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tcw_pkg::tcw_rsp_type           rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_data
);
   import tcw_pkg::*;

   tcw_cmd_type    cmd;
   tcw_status_type status;

   // register writes never wait
   assign csr_ready = 1'b1;

   tcw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

[design/tcw_checker.sv]
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input tcw_pkg::tcw_rsp_type rsp_data
);
   import tcw_pkg::*;

   // a held result keeps its value
   `TCW_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // clearing pass after reset keeps requests out
   `TCW_ASSERT_NXT_ALWAYS(a_reset_busy, clock, reset, req_stall)

   // a scroll always lands on column 0 and reads nothing
   `TCW_ASSERT_IMP(a_scroll_col, clock, reset, rsp_valid && rsp_data.scrolled, rsp_data.cursor_col == '0 && rsp_data.cell_entry == '0)

   // on the top row the linear position is the column
   `TCW_ASSERT_IMP(a_top_row_pos, clock, reset, rsp_valid && rsp_data.cursor_row == '0, rsp_data.cursor_pos == POS_W'(rsp_data.cursor_col))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/text_console_writer_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the text console. Console operations are queued by
// the stimulus process, driven one transaction at a time and mirrored in a
// local screen image with its own cursor and geometry. Every result is
// compared field by field with the image's prediction. The screen geometry
// and colour are changed between phases while the console is idle.
// ---------------------------------------------------------------------------
module text_console_writer_test;
   import tcw_pkg::*;

   // the fourth mode code has no name in the package
   localparam logic [MODE_W-1:0] MODE_NOOP = 2'd3;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tcw_req_type       req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tcw_rsp_type       rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // local copy of the console: screen, cursor and registers
   logic [CELL_W-1:0] screen_image [CELL_COUNT];
   logic [ROW_W-1:0]  crs_row;
   logic [COL_W-1:0]  crs_col;
   logic [COLS_W-1:0] cfg_cols;
   logic [ROWS_W-1:0] cfg_rows;
   logic [CHAR_W-1:0] cfg_color;

   tcw_req_type console_ops[$];
   tcw_rsp_type cursor_reports[$];

   int  err_count     = 0;
   int  results_taken = 0;
   int  scrolls_seen  = 0;
   int  reads_done    = 0;
   int  geometries    = 0;
   int  send_gap      = 0;
   int  stall_left    = 0;
   bit  send_calm     = 1'b0;
   bit  take_calm     = 1'b0;

   text_console_writer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // geometry in use, with out-of-range register values folded back
   function automatic int cols_used();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > MAX_COLS) return MAX_COLS;
      return cfg_cols;
   endfunction

   function automatic int rows_used();
      if (cfg_rows == 0) return 1;
      if (cfg_rows > MAX_ROWS) return MAX_ROWS;
      return cfg_rows;
   endfunction

   // cursor to start of next line, scrolling up at the bottom
   function automatic logic advance_line(input int cols, input int rows);
      crs_col = '0;
      if (crs_row + 1 < rows) begin
         crs_row = crs_row + 1'b1;
         return 1'b0;
      end
      for (int i = cols; i < cols * rows; i++)
         screen_image[i - cols] = screen_image[i];
      for (int i = 0; i < cols; i++)
         screen_image[(rows - 1) * cols + i] = {cfg_color, CH_BLANK};
      crs_row = ROW_W'(rows - 1);
      return 1'b1;
   endfunction

   // effect of one console operation on the image, and its cursor report
   function automatic tcw_rsp_type apply_console_op(input tcw_req_type op);
      tcw_rsp_type res;
      int          cols;
      int          rows;
      int          col_next;
      cols = cols_used();
      rows = rows_used();
      res  = '0;
      if (crs_row >= rows) crs_row = ROW_W'(rows - 1);
      if (crs_col >= cols) crs_col = COL_W'(cols - 1);
      case (op.mode)
         MODE_WRITE: begin
            if (op.char_code == CH_NEWLINE) begin
               res.scrolled = advance_line(cols, rows);
            end else if (op.char_code == CH_BACKSPACE) begin
               // nothing to step back over at the top-left corner
               if (crs_row != 0 || crs_col != 0) begin
                  if (crs_col == 0) begin
                     crs_col = COL_W'(cols - 1);
                     crs_row = crs_row - 1'b1;
                  end else begin
                     crs_col = crs_col - 1'b1;
                  end
                  screen_image[crs_row * cols + crs_col] = {cfg_color, CH_BLANK};
               end
            end else begin
               screen_image[crs_row * cols + crs_col] = {cfg_color, op.char_code};
               col_next = crs_col + 1;
               if (col_next >= cols) res.scrolled = advance_line(cols, rows);
               else crs_col = COL_W'(col_next);
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < cols * rows; i++)
               screen_image[i] = {cfg_color, CH_BLANK};
            crs_row = '0;
            crs_col = '0;
         end
         MODE_READ: begin
            if (op.read_row < rows && op.read_col < cols)
               res.cell_entry = screen_image[op.read_row * cols + op.read_col];
         end
         default: ;
      endcase
      res.cursor_row = crs_row;
      res.cursor_col = crs_col;
      res.cursor_pos = POS_W'(crs_row * cols + crs_col);
      return res;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_span(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      err_count++;
      if (err_count <= 40)
         $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   function automatic void queue_op(input logic [MODE_W-1:0] mode,
                                    input logic [CHAR_W-1:0] ch,
                                    input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col);
      tcw_req_type op;
      op.mode      = mode;
      op.char_code = ch;
      op.read_row  = row;
      op.read_col  = col;
      console_ops.push_back(op);
   endfunction

   // random operation: mostly text with line control, some reads, rare clears
   function automatic tcw_req_type random_op();
      tcw_req_type op;
      int          r;
      r            = $urandom_range(0, 99);
      op.mode      = MODE_WRITE;
      op.char_code = CHAR_W'($urandom_range(32, 126));
      op.read_row  = ROW_W'($urandom);
      op.read_col  = COL_W'($urandom);
      if (r < 12) begin
         op.char_code = CH_NEWLINE;
      end else if (r < 22) begin
         op.char_code = CH_BACKSPACE;
      end else if (r < 30) begin
         op.char_code = CHAR_W'($urandom_range(0, 255));
      end else if (r < 62) begin
         // printable text, fields already set
      end else if (r < 64) begin
         op.mode = MODE_CLEAR;
      end else if (r < 66) begin
         op.mode = MODE_NOOP;
      end else if (r < 92) begin
         op.mode     = MODE_READ;
         op.read_row = ROW_W'($urandom_range(0, rows_used() - 1));
         op.read_col = COL_W'($urandom_range(0, cols_used() - 1));
      end else begin
         op.mode = MODE_READ;
      end
      return op;
   endfunction

   // register write on the csr port, mirrored in the local registers
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_COLS:  cfg_cols  = value;
         CSR_ROWS:  cfg_rows  = value[ROWS_W-1:0];
         CSR_COLOR: cfg_color = value;
         default: ;
      endcase
   endtask

   task automatic retune(input logic [7:0] cols, input logic [7:0] rows,
                         input logic [7:0] color);
      write_register(CSR_COLS, cols);
      write_register(CSR_ROWS, rows);
      write_register(CSR_COLOR, color);
      geometries++;
   endtask

   // hold off until every queued transaction has been answered
   task automatic settle_out();
      do @(negedge clock);
      while (console_ops.size() != 0 || req_valid || cursor_reports.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      logic        hold_valid;
      tcw_rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         hold_valid = req_valid;
         if (req_valid && !req_stall) begin
            want = apply_console_op(req_data);
            cursor_reports.push_back(want);
            if (want.scrolled) scrolls_seen++;
            if (req_data.mode == MODE_READ) reads_done++;
            hold_valid = 1'b0;
            send_gap   = idle_span(send_calm);
         end
         if (!hold_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (console_ops.size() != 0) begin
               req_data   <= console_ops.pop_front();
               hold_valid = 1'b1;
            end
         end
         req_valid <= hold_valid;
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin : rsp_monitor
      tcw_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_taken++;
            if (cursor_reports.size() == 0) begin
               flag_mismatch("result with nothing awaited", 32'(rsp_data.cursor_pos),
                             32'd0);
            end else begin
               want = cursor_reports.pop_front();
               if (rsp_data.cursor_row !== want.cursor_row)
                  flag_mismatch("cursor_row", 32'(rsp_data.cursor_row),
                                32'(want.cursor_row));
               if (rsp_data.cursor_col !== want.cursor_col)
                  flag_mismatch("cursor_col", 32'(rsp_data.cursor_col),
                                32'(want.cursor_col));
               if (rsp_data.cursor_pos !== want.cursor_pos)
                  flag_mismatch("cursor_pos", 32'(rsp_data.cursor_pos),
                                32'(want.cursor_pos));
               if (rsp_data.cell_entry !== want.cell_entry)
                  flag_mismatch("cell_entry", 32'(rsp_data.cell_entry),
                                32'(want.cell_entry));
               if (rsp_data.scrolled !== want.scrolled)
                  flag_mismatch("scrolled", 32'(rsp_data.scrolled),
                                32'(want.scrolled));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_span(take_calm);
         end
      end
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("text_console_writer_test: errors");
      $finish;
   end

   // stimulus
   initial begin
      foreach (screen_image[i]) screen_image[i] = INIT_CELL;
      crs_row   = '0;
      crs_col   = '0;
      cfg_cols  = COLS_RESET;
      cfg_rows  = ROWS_RESET;
      cfg_color = COLOR_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // the store is blanked after reset before the console takes work
      do @(negedge clock); while (req_stall);

      // corners and special characters on the default 80 x 25 screen
      queue_op(MODE_WRITE, CH_BACKSPACE, 0, 0);
      queue_op(MODE_READ, 8'h00, 0, 0);
      queue_op(MODE_WRITE, 8'h00, 31, 127);
      queue_op(MODE_WRITE, 8'hFF, 0, 0);
      queue_op(MODE_WRITE, 8'h41, 0, 0);
      queue_op(MODE_WRITE, CH_NEWLINE, 0, 0);
      queue_op(MODE_WRITE, CH_BACKSPACE, 0, 0);
      queue_op(MODE_READ, 8'h00, 0, 0);
      queue_op(MODE_READ, 8'h00, 0, 1);
      queue_op(MODE_READ, 8'h00, 24, 79);
      queue_op(MODE_READ, 8'h00, 25, 0);
      queue_op(MODE_READ, 8'h00, 0, 80);
      queue_op(MODE_READ, 8'hFF, 31, 127);
      queue_op(MODE_NOOP, 8'hFF, 31, 127);
      queue_op(MODE_CLEAR, 8'h00, 0, 0);
      queue_op(MODE_READ, 8'h00, 0, 1);
      queue_op(MODE_WRITE, CH_NEWLINE, 0, 0);
      queue_op(MODE_WRITE, 8'h7A, 0, 0);
      settle_out();

      // zero geometry acts as one cell: the cursor is pulled in, every
      // character scrolls
      retune(8'd0, 8'd0, 8'hFF);
      queue_op(MODE_READ, 8'h00, 0, 0);
      queue_op(MODE_WRITE, 8'h51, 0, 0);
      queue_op(MODE_READ, 8'h00, 0, 0);
      queue_op(MODE_WRITE, CH_NEWLINE, 0, 0);
      queue_op(MODE_WRITE, CH_BACKSPACE, 0, 0);
      queue_op(MODE_READ, 8'h00, 0, 1);
      settle_out();

      // random phases, mostly on small screens
      for (int p = 0; p < 12; p++) begin
         int          count;
         logic [7:0]  want_cols;
         logic [7:0]  want_rows;
         count     = 50;
         want_cols = 8'($urandom_range(1, 16));
         want_rows = 8'($urandom_range(1, 8));
         if ($urandom_range(0, 4) == 0) want_cols = 8'd0;
         if ($urandom_range(0, 4) == 0) want_rows = 8'd0;
         case (p)
            3: begin want_cols = 8'd128; want_rows = 8'd32; count = 20; end
            5: begin want_cols = 8'd80;  want_rows = 8'd25; count = 60; end
            7: begin want_cols = 8'hFF;  want_rows = 8'hFF; count = 15; end
            9: begin want_cols = 8'd128; want_rows = 8'd1; end
            10: begin want_cols = 8'd1;  want_rows = 8'd32; end
            default: ;
         endcase
         retune(want_cols, want_rows, 8'($urandom_range(0, 255)));
         send_calm = ($urandom_range(0, 3) == 0);
         take_calm = ($urandom_range(0, 3) == 0);
         repeat (count) console_ops.push_back(random_op());
         settle_out();
      end

      repeat (64) @(posedge clock);
      $display("%0d console transactions checked across %0d screen settings",
               results_taken, geometries);
      $display("%0d of them scrolled the screen, %0d read a cell", scrolls_seen, reads_done);
      if (err_count == 0)
         $display("text_console_writer_test: clean");
      else
         $display("text_console_writer_test: errors");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/tcw_pkg.sv
design/tcw_datapath.sv
design/tcw_controller.sv
design/text_console_writer.sv
design/tcw_checker.sv
tb/text_console_writer_test.sv
